[design/mcss_pkg.sv]
// ----------------------------------------------------------------------------
// mcss_pkg: shared constants and types for the mip chain storage size block
// Sizes of the extent, depth, product and sum paths, plus pipeline stage map.
// ----------------------------------------------------------------------------
package mcss_pkg;

  localparam int MAX_LEVELS = 16;
  localparam int MAX_EXTENT = 16384;

  // Fixed field widths
  localparam int IN_EXT_W = 15;
  localparam int DEP_W    = 12;
  localparam int FACE_W   = 3;
  localparam int LVLIN_W  = 5;
  localparam int BPB_W    = 5;
  localparam int TOTAL_W  = 47;

  // Derived internal widths
  localparam int EXT_W  = $clog2(MAX_EXTENT + 1);
  localparam int LVL_W  = $clog2(MAX_LEVELS + 1);
  localparam int FB_W   = FACE_W + BPB_W;
  localparam int P1_W   = 2 * EXT_W;
  localparam int P2_W   = P1_W + DEP_W;
  localparam int TERM_W = P2_W + FB_W;

  // Adder tree over the level lanes
  localparam int TREE_D = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int LANES  = 1 << TREE_D;
  localparam int NODES  = LANES - 1;
  localparam int SUM_W  = TERM_W + TREE_D;

  // Stage map: input, lane prep, w*h, *depth, *faces*bpb, tree, saturate
  localparam int ST_IN    = 0;
  localparam int ST_LANE  = 1;
  localparam int ST_P1    = 2;
  localparam int ST_P2    = 3;
  localparam int ST_TERM  = 4;
  localparam int ST_TREE0 = 5;
  localparam int ST_OUT   = ST_TREE0 + TREE_D;
  localparam int NSTG     = ST_OUT + 1;

  typedef logic [EXT_W-1:0]   ext_t;
  typedef logic [DEP_W-1:0]   dep_t;
  typedef logic [LVL_W-1:0]   lvl_t;
  typedef logic [FB_W-1:0]    fb_t;
  typedef logic [P1_W-1:0]    p1_t;
  typedef logic [P2_W-1:0]    p2_t;
  typedef logic [TERM_W-1:0]  term_t;
  typedef logic [SUM_W-1:0]   sum_t;
  typedef logic [TOTAL_W-1:0] total_t;

  localparam total_t TOTAL_MAX = {TOTAL_W{1'b1}};

endpackage

[design/mip_chain_storage_size.sv]
// ----------------------------------------------------------------------------
// mip_chain_storage_size: total byte size of a texture mip chain
// Sums per-level storage (blocks across * blocks down * depth * faces * bpb)
// over all levels in a fully pipelined datapath, one lane per mip level.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  input   | in_valid / in_ready  | tex_width tex_height tex_depth face_count
//          |                      | mip_levels block_compressed bytes_per_block
//  output  | out_valid / out_ready| total_bytes
//
//  NSTG register stages (10 with sixteen levels): input register, lane prep,
//  three multiply stages, a log2(levels)-deep registered adder tree, saturate.
//  Each result is registered in every one of these stages in turn before it
//  reaches total_bytes. A new transfer is taken every cycle unless an output
//  stall has filled the pipeline; throughput is set by the per-level lanes,
//  each with its own three multipliers.
//  Each stage has its own valid bit; a stage loads when it is empty or the
//  stage after it moves, so bubbles collapse under an output stall.
//  Synchronous active-high reset clears only the valid bits.
//
module mip_chain_storage_size (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [mcss_pkg::IN_EXT_W-1:0]   tex_width,
  input  logic [mcss_pkg::IN_EXT_W-1:0]   tex_height,
  input  logic [mcss_pkg::DEP_W-1:0]      tex_depth,
  input  logic [mcss_pkg::FACE_W-1:0]     face_count,
  input  logic [mcss_pkg::LVLIN_W-1:0]    mip_levels,
  input  logic                            block_compressed,
  input  logic [mcss_pkg::BPB_W-1:0]      bytes_per_block,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mcss_pkg::TOTAL_W-1:0]    total_bytes
);

  localparam int LANES = mcss_pkg::LANES;
  localparam int NSTG  = mcss_pkg::NSTG;

  // Stage valid bits and per-stage load enables
  logic [NSTG-1:0] v;
  logic [NSTG-1:0] en;

  // Input stage
  mcss_pkg::ext_t  w_clamp, h_clamp;
  mcss_pkg::lvl_t  lv_clamp;
  mcss_pkg::fb_t   fb_in;
  logic            any_zero;

  mcss_pkg::ext_t  s0_w, s0_h;
  mcss_pkg::dep_t  s0_d;
  mcss_pkg::fb_t   s0_fb;
  mcss_pkg::lvl_t  s0_lv;
  logic            s0_cmp;

  // Lane stage
  mcss_pkg::ext_t  s1_bw [LANES];
  mcss_pkg::ext_t  s1_bh [LANES];
  mcss_pkg::dep_t  s1_d  [LANES];
  logic [LANES-1:0] s1_on;
  mcss_pkg::fb_t   s1_fb;

  // Multiply stages
  mcss_pkg::p1_t   s2_p1 [LANES];
  mcss_pkg::dep_t  s2_d  [LANES];
  mcss_pkg::fb_t   s2_fb;
  mcss_pkg::p2_t   s3_p2 [LANES];
  mcss_pkg::fb_t   s3_fb;
  mcss_pkg::term_t s4_term [LANES];

  // Adder tree, heap ordered: first level at index 0, root at NODES-1
  mcss_pkg::sum_t  node [mcss_pkg::NODES];
  mcss_pkg::total_t s_out;

  // Clamp extents and levels; a zero width, height, depth, face count or level count means no levels at all
  always_comb begin
    any_zero = (tex_width == '0) || (tex_height == '0) || (tex_depth == '0) ||
               (face_count == '0) || (mip_levels == '0);
    w_clamp = (32'(tex_width) > 32'(mcss_pkg::MAX_EXTENT)) ?
              mcss_pkg::EXT_W'(mcss_pkg::MAX_EXTENT) : mcss_pkg::EXT_W'(tex_width);
    h_clamp = (32'(tex_height) > 32'(mcss_pkg::MAX_EXTENT)) ?
              mcss_pkg::EXT_W'(mcss_pkg::MAX_EXTENT) : mcss_pkg::EXT_W'(tex_height);
    if (any_zero) begin
      lv_clamp = '0;
    end else if (32'(mip_levels) > 32'(mcss_pkg::MAX_LEVELS)) begin
      lv_clamp = mcss_pkg::LVL_W'(mcss_pkg::MAX_LEVELS);
    end else begin
      lv_clamp = mcss_pkg::LVL_W'(mip_levels);
    end
    fb_in = mcss_pkg::FB_W'(face_count) * mcss_pkg::FB_W'(bytes_per_block);
  end

  // Back-pressure: a stage loads when empty or when its successor loads
  always_comb begin
    en[NSTG-1] = !v[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready    = en[mcss_pkg::ST_IN];
  assign out_valid   = v[mcss_pkg::ST_OUT];
  assign total_bytes = s_out;

  // Valid bits advance with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (en[mcss_pkg::ST_IN]) begin
      s0_w   <= w_clamp;
      s0_h   <= h_clamp;
      s0_d   <= tex_depth;
      s0_fb  <= fb_in;
      s0_lv  <= lv_clamp;
      s0_cmp <= block_compressed;
    end
  end

  function automatic mcss_pkg::ext_t blocks(input mcss_pkg::ext_t e, input logic cmp);
    mcss_pkg::ext_t          f;
    logic [mcss_pkg::EXT_W:0] r;
    f = (e == '0) ? mcss_pkg::EXT_W'(1) : e;
    r = ({1'b0, f} + (mcss_pkg::EXT_W + 1)'(3)) >> 2;
    return cmp ? r[mcss_pkg::EXT_W-1:0] : f;
  endfunction

  // Lane prep: level i extents are the base shifted by i, floor 1,
  // then rounded up to whole 4x4 blocks for compressed formats
  always_ff @(posedge clk) begin
    if (en[mcss_pkg::ST_LANE]) begin
      s1_fb <= s0_fb;
      for (int i = 0; i < LANES; i++) begin
        s1_bw[i] <= blocks(s0_w >> i, s0_cmp);
        s1_bh[i] <= blocks(s0_h >> i, s0_cmp);
        s1_d[i]  <= ((s0_d >> i) == '0) ? mcss_pkg::DEP_W'(1) : (s0_d >> i);
        s1_on[i] <= 32'(i) < 32'(s0_lv);
      end
    end
  end

  // Blocks across times blocks down; unused lanes drop to zero here
  always_ff @(posedge clk) begin
    if (en[mcss_pkg::ST_P1]) begin
      s2_fb <= s1_fb;
      for (int i = 0; i < LANES; i++) begin
        s2_p1[i] <= s1_on[i] ? mcss_pkg::P1_W'(s1_bw[i]) * mcss_pkg::P1_W'(s1_bh[i]) : '0;
        s2_d[i]  <= s1_d[i];
      end
    end
  end

  // Times depth
  always_ff @(posedge clk) begin
    if (en[mcss_pkg::ST_P2]) begin
      s3_fb <= s2_fb;
      for (int i = 0; i < LANES; i++) begin
        s3_p2[i] <= mcss_pkg::P2_W'(s2_p1[i]) * mcss_pkg::P2_W'(s2_d[i]);
      end
    end
  end

  // Times faces * bytes per block
  always_ff @(posedge clk) begin
    if (en[mcss_pkg::ST_TERM]) begin
      for (int i = 0; i < LANES; i++) begin
        s4_term[i] <= mcss_pkg::TERM_W'(s3_p2[i]) * mcss_pkg::TERM_W'(s3_fb);
      end
    end
  end

  // Registered adder tree, one level per stage
  always_ff @(posedge clk) begin
    if (en[mcss_pkg::ST_TREE0]) begin
      for (int j = 0; j < (LANES >> 1); j++) begin
        node[j] <= mcss_pkg::SUM_W'(s4_term[2*j]) + mcss_pkg::SUM_W'(s4_term[2*j+1]);
      end
    end
    for (int l = 1; l < mcss_pkg::TREE_D; l++) begin
      if (en[mcss_pkg::ST_TREE0 + l]) begin
        for (int j = 0; j < (LANES >> (l + 1)); j++) begin
          node[LANES - (LANES >> l) + j] <=
            node[LANES - (LANES >> (l - 1)) + 2*j] +
            node[LANES - (LANES >> (l - 1)) + 2*j + 1];
        end
      end
    end
  end

  // Terms are never negative, so clamping the final sum matches a running clamp
  always_ff @(posedge clk) begin
    if (en[mcss_pkg::ST_OUT]) begin
      s_out <= (node[mcss_pkg::NODES-1] > mcss_pkg::SUM_W'(mcss_pkg::TOTAL_MAX)) ?
               mcss_pkg::TOTAL_MAX : node[mcss_pkg::NODES-1][mcss_pkg::TOTAL_W-1:0];
    end
  end

  // Reset empties the whole pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> (v == '0))
    else $error("pipeline not empty after reset");

  // An accepted transfer lands in the input stage
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v[mcss_pkg::ST_IN])
    else $error("accepted transfer lost at input stage");

  // A stalled lane stage keeps its item
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    v[mcss_pkg::ST_LANE] && !en[mcss_pkg::ST_P1] |=> v[mcss_pkg::ST_LANE])
    else $error("stalled item dropped from lane stage");

  // A zero-level item enables no lane
  a_zero_lanes: assert property (@(posedge clk) disable iff (rst)
    en[mcss_pkg::ST_LANE] && (s0_lv == '0) |=> (s1_on == '0))
    else $error("lane enabled for zero-level item");

endmodule
